[hdl/pqse_pkg.sv]
// Shared types and constants for the selective-extract priority queue.
`timescale 1ns / 1ps
package pqse_pkg;

  localparam int unsigned DefDepth       = 16;
  localparam int unsigned DefPayloadBits = 16;
  localparam int unsigned PrioW          = 8;
  localparam int unsigned FieldPayW      = 16;

  typedef enum logic [1:0] {
    OP_PUSH      = 2'd0,
    OP_POP_FRONT = 2'd1,
    OP_POP_EXACT = 2'd2,
    OP_POP_LE    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    mode_e                  mode;
    logic [FieldPayW-1:0]   payload;
    logic [PrioW-1:0]       prio;
  } pqse_in_t;

  typedef struct packed {
    status_e                status;
    logic [FieldPayW-1:0]   out_payload;
    logic [PrioW-1:0]       out_prio;
  } pqse_res_t;

  // Broadcast to every cell in the row.
  typedef struct packed {
    logic                   push_en;
    logic                   pop_en;
    mode_e                  mode;
    logic [PrioW-1:0]       prio;
  } pqse_cmd_t;

  // Contents of one cell as seen by its neighbors.
  typedef struct packed {
    logic                   valid;
    logic [PrioW-1:0]       prio;
  } pqse_link_t;

  // Extraction scan that ripples from the front of the row to the back.
  typedef struct packed {
    logic                   found;
    logic [PrioW-1:0]       prio;
  } pqse_scan_t;

endpackage

[hdl/pqse_cell.sv]
// One slot of the sorted row: holds an entry, shifts on insert and removal.
`timescale 1ns / 1ps
module pqse_cell #(
  parameter int unsigned PAYLOAD_BITS = pqse_pkg::DefPayloadBits
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  pqse_pkg::pqse_cmd_t      cmd_i,
  input  logic [PAYLOAD_BITS-1:0]  new_pay_i,
  // neighbor toward the front
  input  pqse_pkg::pqse_link_t     prev_i,
  input  logic [PAYLOAD_BITS-1:0]  prev_pay_i,
  input  logic                     prev_gt_i,
  // neighbor toward the back
  input  pqse_pkg::pqse_link_t     next_i,
  input  logic [PAYLOAD_BITS-1:0]  next_pay_i,
  // own contents
  output pqse_pkg::pqse_link_t     link_o,
  output logic [PAYLOAD_BITS-1:0]  pay_o,
  output logic                     gt_o,
  // extraction scan
  input  pqse_pkg::pqse_scan_t     scan_i,
  input  logic [PAYLOAD_BITS-1:0]  scan_pay_i,
  output pqse_pkg::pqse_scan_t     scan_o,
  output logic [PAYLOAD_BITS-1:0]  scan_pay_o
);
  import pqse_pkg::*;

  logic                    valid_q, valid_d;
  logic [PrioW-1:0]        prio_q, prio_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic                    hit;
  logic                    rm;

  // Empty slots count as "greater", so the first such slot is the insert point.
  assign gt_o = !valid_q || (prio_q > cmd_i.prio);

  always_comb begin
    case (cmd_i.mode)
      OP_POP_FRONT: hit = valid_q;
      OP_POP_EXACT: hit = valid_q && (prio_q == cmd_i.prio);
      OP_POP_LE:    hit = valid_q && (prio_q <= cmd_i.prio);
      default:      hit = 1'b0;
    endcase
  end

  assign rm = scan_i.found || hit;

  always_comb begin
    scan_o.found = rm;
    if (scan_i.found) begin
      scan_o.prio = scan_i.prio;
      scan_pay_o  = scan_pay_i;
    end else if (hit) begin
      scan_o.prio = prio_q;
      scan_pay_o  = pay_q;
    end else begin
      scan_o.prio = '0;
      scan_pay_o  = '0;
    end
  end

  always_comb begin
    valid_d = valid_q;
    prio_d  = prio_q;
    pay_d   = pay_q;
    if (cmd_i.push_en && gt_o) begin
      if (prev_gt_i) begin
        valid_d = prev_i.valid;
        prio_d  = prev_i.prio;
        pay_d   = prev_pay_i;
      end else begin
        valid_d = 1'b1;
        prio_d  = cmd_i.prio;
        pay_d   = new_pay_i;
      end
    end else if (cmd_i.pop_en && rm) begin
      valid_d = next_i.valid;
      prio_d  = next_i.prio;
      pay_d   = next_pay_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prio_q <= prio_d;
    pay_q  <= pay_d;
  end

  assign link_o.valid = valid_q;
  assign link_o.prio  = prio_q;
  assign pay_o        = pay_q;

endmodule

[hdl/priority_queue_selective_extract_unit.sv]
// Top level: sorted priority queue built as a row of shifting cells.
`timescale 1ns / 1ps
// Takes one operation per clock: busy is never raised, and each accepted
// operation produces exactly one result on res_o with done_o high for one
// cycle, the cycle after start was seen. Push, pop front, pop exact priority
// and pop at-or-below threshold all take the same path: the compare in every
// cell plus the first-hit scan that ripples through the DEPTH cells. No reset
// sweep: the cells' valid bits clear at once.
// Results cannot be held off, so the receiver must take done_o every cycle.
module priority_queue_selective_extract_unit #(
  parameter int unsigned DEPTH        = pqse_pkg::DefDepth,
  parameter int unsigned PAYLOAD_BITS = pqse_pkg::DefPayloadBits
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  pqse_pkg::pqse_in_t   in_i,
  output logic                 done_o,
  output pqse_pkg::pqse_res_t  res_o
);
  import pqse_pkg::*;

  logic                    accept;
  logic                    full;
  logic                    empty;
  pqse_cmd_t               cmd;
  logic [PAYLOAD_BITS-1:0] new_pay;

  pqse_link_t              link   [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay    [DEPTH];
  logic                    gt     [DEPTH];
  pqse_scan_t              scan   [DEPTH+1];
  logic [PAYLOAD_BITS-1:0] scan_p [DEPTH+1];
  logic [DEPTH-1:0]        valid_vec;

  logic                    done_q;
  pqse_res_t               res_q, res_d;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign full    = link[DEPTH-1].valid;
  assign empty   = !link[0].valid;
  assign new_pay = PAYLOAD_BITS'(in_i.payload);

  assign cmd.push_en = accept && (in_i.mode == OP_PUSH) && !full;
  assign cmd.pop_en  = accept && (in_i.mode != OP_PUSH);
  assign cmd.mode    = in_i.mode;
  assign cmd.prio    = in_i.prio;

  assign scan[0]   = '0;
  assign scan_p[0] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pqse_link_t              prev_l, next_l;
    logic [PAYLOAD_BITS-1:0] prev_p, next_p;
    logic                    prev_gt;

    if (i == 0) begin : g_front
      assign prev_l  = '0;
      assign prev_p  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_mid
      assign prev_l  = link[i-1];
      assign prev_p  = pay[i-1];
      assign prev_gt = gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign next_l = '0;
      assign next_p = '0;
    end else begin : g_body
      assign next_l = link[i+1];
      assign next_p = pay[i+1];
    end

    pqse_cell #(
      .PAYLOAD_BITS(PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .new_pay_i  (new_pay),
      .prev_i     (prev_l),
      .prev_pay_i (prev_p),
      .prev_gt_i  (prev_gt),
      .next_i     (next_l),
      .next_pay_i (next_p),
      .link_o     (link[i]),
      .pay_o      (pay[i]),
      .gt_o       (gt[i]),
      .scan_i     (scan[i]),
      .scan_pay_i (scan_p[i]),
      .scan_o     (scan[i+1]),
      .scan_pay_o (scan_p[i+1])
    );

    assign valid_vec[i] = link[i].valid;
  end

  always_comb begin
    res_d = '0;
    if (in_i.mode == OP_PUSH) begin
      res_d.status = full ? ST_FULL : ST_OK;
    end else if (empty) begin
      res_d.status = ST_EMPTY;
    end else if (!scan[DEPTH].found) begin
      res_d.status = ST_NOMATCH;
    end else begin
      res_d.status      = ST_OK;
      res_d.out_payload = FieldPayW'(scan_p[DEPTH]);
      res_d.out_prio    = scan[DEPTH].prio;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // Every accepted transaction yields a result in the next cycle.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("accepted transaction produced no result");

  // Occupied cells always form a contiguous run from the front.
  a_packed_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("gap in occupied cells");

  // A push into a full row is refused and leaves the row full.
  a_full_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.mode == OP_PUSH) && full) |=>
      (res_o.status == ST_FULL) && full)
    else $error("push into full queue not rejected");

  // A successful pop frees exactly one cell.
  a_pop_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.pop_en && scan[DEPTH].found) |=>
      ($countones(valid_vec) + 1 == $countones($past(valid_vec))))
    else $error("pop did not remove exactly one entry");
`endif

endmodule
